[rtl/hst_pkg.sv]
// ============================================================================
// hst_pkg - shared types and constants of the hashed slot table
// Item, result and queue entry layouts, operation and status codes,
// configuration register indexes.
// ============================================================================
`default_nettype none

package hst_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTER_MODE = 2'd1;

  // Reset values of the configuration registers
  localparam logic [CFG_DATA_W-1:0] SLOT_COUNT_RESET = 9'd256;

  // Operation codes carried in an item
  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_GET  = 2'd1,
    KIND_FILL = 2'd2
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MODE  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  key_char;
    logic        key_last;
    logic [63:0] value;
  } item_t;

  typedef struct packed {
    logic [63:0] read_value;
    status_e     status;
    logic [7:0]  slot_index;
  } result_t;

  // Entry of the command queue between front and back
  typedef struct packed {
    kind_e       kind;
    logic [63:0] hash;
    logic [63:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Command queue geometry
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Modulo unit: remainder digits folded per cycle and folding steps per hash
  localparam int MOD_DIGITS  = 4;
  localparam int MOD_STEPS   = 64 / MOD_DIGITS;
  localparam int MOD_CNT_W   = 4;

endpackage

`default_nettype wire

[rtl/hashed_slot_table_core.sv]
// ============================================================================
// hashed_slot_table_core - direct-mapped string-keyed slot table
// Keys stream in one byte per transfer; a nonzero byte hashes as
// h = h*97 + byte. The last byte reduces the hash modulo the slot count and
// sets or gets that slot. Outside pointer mode a fill writes every live slot.
// ============================================================================
//
//   channel   direction  handshake                 payload
//   -------   ---------  ------------------------  ------------------------
//   item      in         start_i high, busy_o low  item_i   (hst_pkg::item_t)
//   result    out        result_valid_o, 1 cycle   result_o (hst_pkg::result_t)
//   config    in         cfg_we_i high             cfg_idx_i, cfg_data_i
//
// Flow: key bytes are taken one per cycle while busy_o is low. A finished
// set or get key pops the queue and runs the modulo unit, which folds four
// hash bits per cycle; the back part then takes the remainder (and writes,
// for a set), and a get waits on the registered memory read. The result
// strobes in the cycle after that.
// A fill writes each live slot, one slot write per cycle on the
// memory's single write port.
// Reset: after reset a clearing pass writes zero to all TABLE_DEPTH slots,
// one per cycle; busy_o stays high throughout the pass. Stalls: busy_o
// also rises when the two-entry command queue is full; key bytes keep
// flowing while the back part works. The receiver cannot stall.
// ============================================================================
`default_nettype none

module hashed_slot_table_core #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_BITS  = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // item transfer
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire hst_pkg::item_t                   item_i,
  // result transfer
  output logic                                  result_valid_o,
  output hst_pkg::result_t                      result_o,
  // configuration writes
  input  wire logic                             cfg_we_i,
  input  wire logic [hst_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [hst_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // Width of a slot count 1..TABLE_DEPTH, and of a slot index
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [hst_pkg::CFG_DATA_W-1:0] slot_count_q;
  logic                           pointer_mode_q;
  logic [CNT_W-1:0]               live_slots;
  logic [31:0]                    live_wide;

  logic                           push;
  hst_pkg::cmd_t                  push_cmd;
  logic                           pop;
  hst_pkg::cmd_t                  head;
  hst_pkg::queue_stat_t           queue_stat;
  logic                           clearing;

  // Configuration registers: to be written by the user only while idle, so the
  // back part may read them live; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q   <= hst_pkg::SLOT_COUNT_RESET;
      pointer_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hst_pkg::CFG_SLOT_COUNT:   slot_count_q   <= cfg_data_i;
        hst_pkg::CFG_POINTER_MODE: pointer_mode_q <= cfg_data_i[0];
        default: begin
          // drop: no register at this index
        end
      endcase
    end
  end

  // Live slot count: zero acts as one, saturate at the table depth
  always_comb begin
    if (slot_count_q == '0) begin
      live_wide = 32'd1;
    end else if (32'(slot_count_q) > 32'(TABLE_DEPTH)) begin
      live_wide = 32'(TABLE_DEPTH);
    end else begin
      live_wide = 32'(slot_count_q);
    end
  end
  assign live_slots = live_wide[CNT_W-1:0];

  // Hold off new items while the queue is full or the store is clearing
  assign busy_o = queue_stat.full || clearing;

  hst_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stall_i (busy_o),
    .item_i  (item_i),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  hst_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (queue_stat)
  );

  hst_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS),
    .CNT_W       (CNT_W),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .live_slots_i   (live_slots),
    .pointer_mode_i (pointer_mode_q),
    .head_i         (head),
    .queue_i        (queue_stat),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

[rtl/hst_front.sv]
// ============================================================================
// hst_front - key byte intake and hash accumulator
// Folds key bytes into the running hash and queues one command per
// finished key or fill.
// ============================================================================
`default_nettype none

module hst_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic           stall_i,
  input  wire hst_pkg::item_t item_i,
  output logic                push_o,
  output hst_pkg::cmd_t       cmd_o
);

  logic [63:0] hash_q, hash_d;
  logic [63:0] hash_step;
  logic        accept;

  assign accept = start_i && !stall_i;

  // hash * 97 = hash * 64 + hash * 32 + hash, modulo 2^64
  always_comb begin
    if (item_i.key_char != 8'd0) begin
      hash_step = {hash_q[57:0], 6'b0} + {hash_q[58:0], 5'b0} + hash_q
                + {56'd0, item_i.key_char};
    end else begin
      hash_step = hash_q;
    end
  end

  always_comb begin
    hash_d       = hash_q;
    push_o       = 1'b0;
    cmd_o.kind   = hst_pkg::KIND_SET;
    cmd_o.hash   = hash_step;
    cmd_o.value  = item_i.value;
    if (accept) begin
      case (item_i.kind)
        hst_pkg::KIND_SET, hst_pkg::KIND_GET: begin
          cmd_o.kind = hst_pkg::kind_e'(item_i.kind);
          if (item_i.key_last) begin
            push_o = 1'b1;
            hash_d = 64'd0;
          end else begin
            hash_d = hash_step;
          end
        end
        hst_pkg::KIND_FILL: begin
          cmd_o.kind = hst_pkg::KIND_FILL;
          push_o     = 1'b1;
        end
        default: begin
          // drop: unused kind code
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= 64'd0;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

`default_nettype wire

[rtl/hst_fifo.sv]
// ============================================================================
// hst_fifo - command queue between front and back
// Two-entry first-in first-out queue of pending table commands.
// ============================================================================
`default_nettype none

module hst_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire hst_pkg::cmd_t   cmd_i,
  input  wire logic            pop_i,
  output hst_pkg::cmd_t        head_o,
  output hst_pkg::queue_stat_t stat_o
);

  hst_pkg::cmd_t                   entry_q [hst_pkg::QUEUE_DEPTH];
  logic [hst_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [hst_pkg::QUEUE_CNT_W-1:0] count_q;

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == hst_pkg::QUEUE_CNT_W'(hst_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !stat_o.full)
    else $error("command queue overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("command queue underflow");

endmodule

`default_nettype wire

[rtl/hst_mod.sv]
// ============================================================================
// hst_mod - iterative hash reduction
// Reduces a 64-bit hash modulo the live slot count, several remainder
// digits per cycle.
// ============================================================================
`default_nettype none

module hst_mod #(
  parameter int CNT_W = 9
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [63:0]      dividend_i,
  input  wire logic [CNT_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [CNT_W-1:0]      rem_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [hst_pkg::MOD_CNT_W-1:0] cnt_q;
  logic [63:0]                   div_q;
  logic [CNT_W-1:0]              rem_q;
  logic [CNT_W:0]                rem_next;
  logic [63:0]                   div_next;

  // Restoring reduction: shift in one dividend bit, subtract when it fits
  always_comb begin
    rem_next = {1'b0, rem_q};
    div_next = div_q;
    for (int k = 0; k < hst_pkg::MOD_DIGITS; k++) begin
      rem_next = {rem_next[CNT_W-1:0], div_next[63]};
      div_next = {div_next[62:0], 1'b0};
      if (rem_next >= {1'b0, divisor_i}) begin
        rem_next = rem_next - {1'b0, divisor_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      div_q <= div_next;
      rem_q <= rem_next[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == hst_pkg::MOD_CNT_W'(hst_pkg::MOD_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < divisor_i)
    else $error("remainder not below slot count");

endmodule

`default_nettype wire

[rtl/hst_back.sv]
// ============================================================================
// hst_back - table sequencer and slot memory
// Clears the store after reset, then pops commands and carries out set,
// get and fill against the slot memory.
// ============================================================================
`default_nettype none

module hst_back #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_BITS  = 64,
  parameter int CNT_W       = 9,
  parameter int IDX_W       = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [CNT_W-1:0]     live_slots_i,
  input  wire logic                 pointer_mode_i,
  input  wire hst_pkg::cmd_t        head_i,
  input  wire hst_pkg::queue_stat_t queue_i,
  output logic                      pop_o,
  output logic                      clearing_o,
  output logic                      result_valid_o,
  output hst_pkg::result_t          result_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [IDX_W-1:0]      cnt_q, cnt_d;
  hst_pkg::cmd_t         cur_q, cur_d;
  logic [IDX_W-1:0]      slot_q, slot_d;
  logic                  res_valid_q, res_valid_d;
  hst_pkg::result_t      res_q, res_d;

  logic                  mod_start;
  logic                  mod_done;
  logic [CNT_W-1:0]      mod_rem;

  logic [VALUE_BITS-1:0] mem [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] rd_data_q;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [IDX_W-1:0]      rem_idx;
  logic [63:0]           rd_value;

  function automatic logic [7:0] slot8(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[7:0];
  endfunction

  hst_mod #(
    .CNT_W (CNT_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (head_i.hash),
    .divisor_i  (live_slots_i),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign rem_idx  = mod_rem[IDX_W-1:0];
  assign rd_value = 64'(rd_data_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    slot_d      = slot_q;
    pop_o       = 1'b0;
    mod_start   = 1'b0;
    we          = 1'b0;
    waddr       = cnt_q;
    wdata       = '0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        if (cnt_q == IDX_W'(TABLE_DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (!queue_i.empty) begin
          pop_o = 1'b1;
          cur_d = head_i;
          case (head_i.kind)
            hst_pkg::KIND_FILL: begin
              if (pointer_mode_i) begin
                res_valid_d      = 1'b1;
                res_d.read_value = 64'd0;
                res_d.status     = hst_pkg::ST_MODE;
                res_d.slot_index = 8'd0;
              end else begin
                cnt_d   = '0;
                state_d = S_FILL;
              end
            end
            hst_pkg::KIND_SET, hst_pkg::KIND_GET: begin
              mod_start = 1'b1;
              state_d   = S_MOD;
            end
            default: begin
              // drop: never queued
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          slot_d = rem_idx;
          if (cur_q.kind == hst_pkg::KIND_SET) begin
            we               = 1'b1;
            waddr            = rem_idx;
            wdata            = cur_q.value[VALUE_BITS-1:0];
            res_valid_d      = 1'b1;
            res_d.read_value = 64'd0;
            res_d.status     = hst_pkg::ST_OK;
            res_d.slot_index = slot8(rem_idx);
            state_d          = S_IDLE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        res_valid_d      = 1'b1;
        res_d.read_value = rd_value;
        res_d.status     = (pointer_mode_i && rd_value == 64'd0) ? hst_pkg::ST_EMPTY
                                                                 : hst_pkg::ST_OK;
        res_d.slot_index = slot8(slot_q);
        state_d          = S_IDLE;
      end
      S_FILL: begin
        we    = 1'b1;
        wdata = cur_q.value[VALUE_BITS-1:0];
        if (CNT_W'(cnt_q) == live_slots_i - 1'b1) begin
          cnt_d            = '0;
          res_valid_d      = 1'b1;
          res_d.read_value = 64'd0;
          res_d.status     = hst_pkg::ST_OK;
          res_d.slot_index = 8'd0;
          state_d          = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Slot memory: one write port, one registered read port addressed by the
  // reduced hash
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[rem_idx];
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    slot_q <= slot_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign clearing_o     = (state_q == S_CLEAR);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !res_valid_q && !pop_o)
    else $error("activity during clearing pass");

endmodule

`default_nettype wire
